@@ hw/rtl/sdspi_pkg.sv @@
// sdspi_pkg: shared types and codes of the sd card spi host sequencer
// word layouts of the request and response channels, operation and status codes
// no dependencies
`default_nettype none

package sdspi_pkg;

	localparam int BLOCK_BYTES_DEF = 512;

	typedef enum logic [3:0] {
		OP_INIT   = 4'd0,
		OP_STATUS = 4'd1,
		OP_READ   = 4'd2,
		OP_WRITE  = 4'd3,
		OP_SYNC   = 4'd4,
		OP_SCOUNT = 4'd5,
		OP_SSIZE  = 4'd6,
		OP_BSIZE  = 4'd7,
		OP_SPI    = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ERR    = 2'd1,
		ST_NOTRDY = 2'd2,
		ST_PARAM  = 2'd3
	} status_t;

	// command index bytes, start bit included
	localparam logic [7:0] C_GO_IDLE  = 8'h40;
	localparam logic [7:0] C_IF_COND  = 8'h48;
	localparam logic [7:0] C_APP      = 8'h77;
	localparam logic [7:0] C_OP_COND  = 8'h69;
	localparam logic [7:0] C_READ_OCR = 8'h7A;
	localparam logic [7:0] C_READ_ONE = 8'h51;
	localparam logic [7:0] C_WRITE_ONE = 8'h58;

	localparam logic [7:0] CRC_GO_IDLE = 8'h95;
	localparam logic [7:0] CRC_IF_COND = 8'h87;
	localparam logic [7:0] CRC_OTHER   = 8'h01;

	localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
	localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
	localparam logic [7:0]  DATA_TOKEN  = 8'hFE;
	localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
	localparam logic [4:0]  DRESP_OK    = 5'h05;
	localparam logic [16:0] SECTOR_COUNT = 17'd65536;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_V1   = 3'd1;
	localparam logic [2:0] KIND_V2   = 3'd2;
	localparam logic [2:0] KIND_HC   = 3'd6;

	// register indexes on the config port
	localparam logic [1:0] REG_READY_TO = 2'd0;
	localparam logic [1:0] REG_RESP_POLLS = 2'd1;
	localparam logic [1:0] REG_INIT_RETRIES = 2'd2;
	localparam logic [1:0] REG_TOKEN_TO = 2'd3;

	typedef struct packed {
		logic [3:0]  command;
		logic        drive_number;
		logic [31:0] sector;
		logic [7:0]  block_count;
		logic [7:0]  miso_byte;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]  mosi_byte;
		logic        exchange_request;
		logic        chip_select_active;
		logic [7:0]  read_byte;
		logic        read_valid;
		logic        write_byte_taken;
		logic        done_res;
		logic [1:0]  status;
		logic        not_initialized;
		logic [16:0] info_value;
	} rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/sd_card_spi_host_sequencer.sv @@
// sd card spi host sequencer: one request or exchanged byte word in, one response word out
// path: the request word passes the input register, then the result register, where its
// response word is valid until it is taken
// throughput: one word per cycle; the next-step logic between the two registers is one pass,
// the input stalls only while a response word waits in the result register
// reset: arst_n clears both pipeline valids, phase to idle, card marked uninitialized,
// config registers to their defaults (65535, 10, 25000, 50000)
`default_nettype none

module sd_card_spi_host_sequencer #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request channel
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire sdspi_pkg::req_t  req,
	// response channel
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output sdspi_pkg::rsp_t       rsp,
	// config port
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [3:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import sdspi_pkg::*;

	localparam int BC_W = $clog2(BLOCK_BYTES);

	// one-hot sequencer phase
	typedef enum logic [16:0] {
		P_IDLE   = 17'h00001,
		P_WAKE   = 17'h00002,
		P_RDY    = 17'h00004,
		P_FRAME  = 17'h00008,
		P_R1     = 17'h00010,
		P_OCR    = 17'h00020,
		P_TOKEN  = 17'h00040,
		P_RDATA  = 17'h00080,
		P_RCRC   = 17'h00100,
		P_WGAP   = 17'h00200,
		P_WTOKEN = 17'h00400,
		P_WDATA  = 17'h00800,
		P_WCRC   = 17'h01000,
		P_WRESP  = 17'h02000,
		P_WBUSY  = 17'h04000,
		P_SYNC   = 17'h08000,
		P_TAIL   = 17'h10000
	} phase_t;

	// config registers
	logic [15:0] ready_to_q, retries_q, token_to_q;
	logic [7:0]  resp_polls_q;

	// sequencer state
	phase_t      phase_q;
	logic        uninit_q;
	logic [2:0]  cur_op_q;
	logic [BC_W-1:0] byte_q;
	logic [15:0] poll_q;
	logic [15:0] retry_q;
	logic [47:0] frame_q;
	logic [31:0] ocr_q;
	logic [2:0]  kind_q;
	logic        v2_q;
	logic [1:0]  fin_st_q;

	// pipeline
	logic        valid_s1;
	req_t        req_s1;
	logic        adv;

	// ---------------- config port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_to_q   <= 16'd65535;
			resp_polls_q <= 8'd10;
			retries_q    <= 16'd25000;
			token_to_q   <= 16'd50000;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_READY_TO:     ready_to_q   <= pwdata[15:0];
				REG_RESP_POLLS:   resp_polls_q <= pwdata[7:0];
				REG_INIT_RETRIES: retries_q    <= pwdata[15:0];
				REG_TOKEN_TO:     token_to_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_READY_TO:     prdata = {16'd0, ready_to_q};
			REG_RESP_POLLS:   prdata = {24'd0, resp_polls_q};
			REG_INIT_RETRIES: prdata = {16'd0, retries_q};
			REG_TOKEN_TO:     prdata = {16'd0, token_to_q};
			default:          prdata = 32'd0;
		endcase
	end

	// ---------------- handshake ----------------
	// s1 moves on whenever the result register is empty or being drained
	assign adv       = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// ---------------- next-step logic ----------------
	phase_t      n_phase;
	logic        n_uninit;
	logic [2:0]  n_op;
	logic [BC_W-1:0] n_byte;
	logic [15:0] n_poll, n_retry;
	logic [47:0] n_frame;
	logic [31:0] n_ocr;
	logic [2:0]  n_kind;
	logic        n_v2;
	logic [1:0]  n_fin;
	rsp_t        r;

	always_comb begin
		logic        do_resp, do_acmd, do_end, do_send, do_fin, do_issue, do_rep;
		logic [7:0]  resp_r, send_c, crc, iss_mosi, miso;
		logic [31:0] send_arg;
		logic [2:0]  end_ty, rep_op;
		logic [1:0]  fin_st, rep_st;
		logic        iss_cs, rep_ni;
		phase_t      iss_ph;
		logic [2:0]  fidx;
		logic [BC_W-1:0] last_byte;

		n_phase  = phase_q;
		n_uninit = uninit_q;
		n_op     = cur_op_q;
		n_byte   = byte_q;
		n_poll   = poll_q;
		n_retry  = retry_q;
		n_frame  = frame_q;
		n_ocr    = ocr_q;
		n_kind   = kind_q;
		n_v2     = v2_q;
		n_fin    = fin_st_q;

		do_resp = 1'b0; do_acmd = 1'b0; do_end = 1'b0; do_send = 1'b0;
		do_fin = 1'b0; do_issue = 1'b0; do_rep = 1'b0;
		resp_r = 8'd0; send_c = 8'd0; send_arg = 32'd0; crc = CRC_OTHER;
		end_ty = KIND_NONE; fin_st = ST_OK; rep_op = 3'd0; rep_st = ST_OK; rep_ni = 1'b0;
		iss_mosi = IDLE_BYTE; iss_cs = 1'b0; iss_ph = P_IDLE;
		fidx = 3'd0;
		miso = req_s1.miso_byte;
		last_byte = BC_W'(BLOCK_BYTES - 1);

		r = '0;
		r.not_initialized = uninit_q;

		case (phase_q)
			P_IDLE: begin
				if (req_s1.command == OP_SPI) begin
					// stray spi byte while idle: empty result
				end else if (req_s1.command > OP_SPI) begin
					do_rep = 1'b1; rep_op = 3'd0; rep_st = ST_PARAM; rep_ni = uninit_q;
				end else begin
					n_op = req_s1.command[2:0];
					if (req_s1.command == OP_INIT || req_s1.command == OP_STATUS) begin
						if (req_s1.drive_number) begin
							do_rep = 1'b1; rep_op = req_s1.command[2:0];
							rep_st = ST_PARAM; rep_ni = 1'b1;
						end else if (req_s1.command == OP_STATUS) begin
							do_rep = 1'b1; rep_op = req_s1.command[2:0];
							rep_st = ST_OK; rep_ni = uninit_q;
						end else begin
							n_byte = '0;
							do_issue = 1'b1; iss_cs = 1'b0; iss_ph = P_WAKE;
						end
					end else if (req_s1.drive_number ||
						((req_s1.command == OP_READ || req_s1.command == OP_WRITE) &&
						 req_s1.block_count == 8'd0)) begin
						do_rep = 1'b1; rep_op = req_s1.command[2:0];
						rep_st = ST_PARAM; rep_ni = uninit_q;
					end else if (uninit_q) begin
						do_rep = 1'b1; rep_op = req_s1.command[2:0];
						rep_st = ST_NOTRDY; rep_ni = uninit_q;
					end else if (req_s1.command == OP_READ || req_s1.command == OP_WRITE) begin
						if (req_s1.block_count != 8'd1) begin
							do_fin = 1'b1; fin_st = ST_ERR;
						end else begin
							do_send = 1'b1;
							send_c = (req_s1.command == OP_READ) ? C_READ_ONE : C_WRITE_ONE;
							send_arg = req_s1.sector;
						end
					end else if (req_s1.command == OP_SYNC) begin
						n_poll = 16'd1;
						do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_SYNC;
					end else begin
						do_fin = 1'b1; fin_st = ST_OK;
					end
				end
			end
			P_WAKE: begin
				n_byte = byte_q + 1'b1;
				if (n_byte < BC_W'(10)) begin
					do_issue = 1'b1; iss_cs = 1'b0; iss_ph = P_WAKE;
				end else begin
					do_send = 1'b1; send_c = C_GO_IDLE; send_arg = 32'd0;
				end
			end
			P_RDY: begin
				if (miso == IDLE_BYTE) begin
					n_byte = '0;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_FRAME;
					iss_mosi = frame_q[47:40];
				end else if (poll_q >= ready_to_q) begin
					do_resp = 1'b1; resp_r = IDLE_BYTE;
				end else begin
					n_poll = poll_q + 16'd1;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_RDY;
				end
			end
			P_FRAME: begin
				n_byte = byte_q + 1'b1;
				if (n_byte < BC_W'(6)) begin
					fidx = n_byte[2:0];
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_FRAME;
					case (fidx)
						3'd1:    iss_mosi = frame_q[39:32];
						3'd2:    iss_mosi = frame_q[31:24];
						3'd3:    iss_mosi = frame_q[23:16];
						3'd4:    iss_mosi = frame_q[15:8];
						3'd5:    iss_mosi = frame_q[7:0];
						default: iss_mosi = frame_q[47:40];
					endcase
				end else begin
					n_poll = 16'd1;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_R1;
				end
			end
			P_R1: begin
				if (!miso[7] || poll_q >= {8'd0, resp_polls_q}) begin
					do_resp = 1'b1; resp_r = miso;
				end else begin
					n_poll = poll_q + 16'd1;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_R1;
				end
			end
			P_OCR: begin
				n_ocr  = {ocr_q[23:0], miso};
				n_byte = byte_q + 1'b1;
				if (n_byte < BC_W'(4)) begin
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_OCR;
				end else if (frame_q[47:40] == C_IF_COND) begin
					if (n_ocr[15:0] == ARG_IF_COND[15:0]) begin
						n_v2 = 1'b1;
						n_retry = retries_q;
						do_acmd = 1'b1;
					end else begin
						do_end = 1'b1; end_ty = KIND_NONE;
					end
				end else begin
					do_end = 1'b1; end_ty = n_ocr[30] ? KIND_HC : KIND_V2;
				end
			end
			P_TOKEN: begin
				if (miso == DATA_TOKEN) begin
					n_byte = '0;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_RDATA;
				end else if (poll_q >= token_to_q) begin
					do_fin = 1'b1; fin_st = ST_ERR;
				end else begin
					n_poll = poll_q + 16'd1;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_TOKEN;
				end
			end
			P_RDATA: begin
				r.read_byte  = miso;
				r.read_valid = 1'b1;
				do_issue = 1'b1; iss_cs = 1'b1;
				if (byte_q != last_byte) begin
					n_byte = byte_q + 1'b1; iss_ph = P_RDATA;
				end else begin
					n_byte = '0; iss_ph = P_RCRC;
				end
			end
			P_RCRC: begin
				if (byte_q == '0) begin
					n_byte = BC_W'(1);
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_RCRC;
				end else begin
					do_fin = 1'b1; fin_st = ST_OK;
				end
			end
			P_WGAP: begin
				do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_WTOKEN; iss_mosi = DATA_TOKEN;
			end
			P_WTOKEN: begin
				n_byte = '0;
				r.write_byte_taken = 1'b1;
				do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_WDATA;
				iss_mosi = req_s1.write_byte;
			end
			P_WDATA: begin
				do_issue = 1'b1; iss_cs = 1'b1;
				if (byte_q != last_byte) begin
					n_byte = byte_q + 1'b1;
					r.write_byte_taken = 1'b1;
					iss_ph = P_WDATA; iss_mosi = req_s1.write_byte;
				end else begin
					n_byte = '0; iss_ph = P_WCRC;
				end
			end
			P_WCRC: begin
				do_issue = 1'b1; iss_cs = 1'b1;
				if (byte_q == '0) begin
					n_byte = BC_W'(1); iss_ph = P_WCRC;
				end else begin
					iss_ph = P_WRESP;
				end
			end
			P_WRESP: begin
				if (miso[4:0] == DRESP_OK) begin
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_WBUSY;
				end else begin
					do_fin = 1'b1; fin_st = ST_ERR;
				end
			end
			P_WBUSY: begin
				if (miso == 8'd0) begin
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_WBUSY;
				end else begin
					do_fin = 1'b1; fin_st = ST_OK;
				end
			end
			P_SYNC: begin
				if (miso == IDLE_BYTE) begin
					do_fin = 1'b1; fin_st = ST_OK;
				end else if (poll_q >= ready_to_q) begin
					do_fin = 1'b1; fin_st = ST_ERR;
				end else begin
					n_poll = poll_q + 16'd1;
					do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_SYNC;
				end
			end
			P_TAIL: begin
				n_phase = P_IDLE;
				do_rep = 1'b1; rep_op = cur_op_q; rep_st = fin_st_q; rep_ni = uninit_q;
			end
			default: begin
				n_phase = P_IDLE;
			end
		endcase

		// r1 response handling, keyed by the command in the frame
		if (do_resp) begin
			case (frame_q[47:40])
				C_GO_IDLE: begin
					if (resp_r == 8'd1) begin
						do_send = 1'b1; send_c = C_IF_COND; send_arg = ARG_IF_COND;
					end else begin
						do_end = 1'b1; end_ty = KIND_NONE;
					end
				end
				C_IF_COND: begin
					if (resp_r == 8'd1) begin
						n_byte = '0; n_ocr = 32'd0;
						do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_OCR;
					end else begin
						n_v2 = 1'b0;
						do_send = 1'b1; send_c = C_APP;
					end
				end
				C_APP: begin
					if (resp_r <= 8'd1) begin
						do_send = 1'b1; send_c = C_OP_COND;
						send_arg = v2_q ? ARG_HCS : 32'd0;
					end else if (v2_q) begin
						do_acmd = 1'b1;
					end else begin
						do_end = 1'b1; end_ty = KIND_V1;
					end
				end
				C_OP_COND: begin
					if (v2_q) begin
						if (resp_r == 8'd0) begin
							do_send = 1'b1; send_c = C_READ_OCR;
						end else begin
							do_acmd = 1'b1;
						end
					end else begin
						do_end = 1'b1; end_ty = (resp_r <= 8'd1) ? KIND_V2 : KIND_V1;
					end
				end
				C_READ_OCR: begin
					if (resp_r == 8'd0) begin
						n_byte = '0; n_ocr = 32'd0;
						do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_OCR;
					end else begin
						do_end = 1'b1; end_ty = KIND_NONE;
					end
				end
				C_READ_ONE: begin
					if (resp_r == 8'd0) begin
						n_poll = 16'd1;
						do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_TOKEN;
					end else begin
						do_fin = 1'b1; fin_st = ST_ERR;
					end
				end
				C_WRITE_ONE: begin
					if (resp_r == 8'd0) begin
						do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_WGAP;
					end else begin
						do_fin = 1'b1; fin_st = ST_ERR;
					end
				end
				default: begin
					do_fin = 1'b1; fin_st = ST_ERR;
				end
			endcase
		end

		// one acmd41 attempt: cmd55 first, or give up when attempts are spent
		if (do_acmd) begin
			if (n_retry == 16'd0) begin
				do_end = 1'b1; end_ty = KIND_NONE;
			end else begin
				n_retry = n_retry - 16'd1;
				do_send = 1'b1; send_c = C_APP; send_arg = 32'd0;
			end
		end

		if (do_end) begin
			n_kind   = end_ty;
			n_uninit = (end_ty == KIND_NONE);
			do_fin   = 1'b1; fin_st = ST_OK;
		end

		// build a frame and start polling for not-busy
		if (do_send) begin
			if (send_c == C_GO_IDLE) crc = CRC_GO_IDLE;
			else if (send_c == C_IF_COND) crc = CRC_IF_COND;
			n_frame = {send_c, send_arg, crc};
			n_poll  = 16'd1;
			do_issue = 1'b1; iss_cs = 1'b1; iss_ph = P_RDY; iss_mosi = IDLE_BYTE;
		end

		// closing 0xff with chip select released
		if (do_fin) begin
			n_fin = fin_st;
			do_issue = 1'b1; iss_cs = 1'b0; iss_ph = P_TAIL; iss_mosi = IDLE_BYTE;
		end

		if (do_issue) begin
			r.mosi_byte          = iss_mosi;
			r.exchange_request   = 1'b1;
			r.chip_select_active = iss_cs;
			n_phase              = iss_ph;
		end

		if (do_rep) begin
			n_op              = rep_op;
			r.done_res        = 1'b1;
			r.status          = rep_st;
			r.not_initialized = rep_ni;
			if (rep_st == ST_OK) begin
				case (rep_op)
					OP_SCOUNT[2:0]: r.info_value = SECTOR_COUNT;
					OP_SSIZE[2:0]:  r.info_value = 17'(BLOCK_BYTES);
					OP_BSIZE[2:0]:  r.info_value = 17'd1;
					default:        r.info_value = 17'd0;
				endcase
			end
		end
	end

	// ---------------- state and result registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_IDLE;
			uninit_q <= 1'b1;
			cur_op_q <= 3'd0;
			byte_q   <= '0;
			poll_q   <= 16'd0;
			retry_q  <= 16'd0;
			frame_q  <= 48'd0;
			ocr_q    <= 32'd0;
			kind_q   <= KIND_NONE;
			v2_q     <= 1'b0;
			fin_st_q <= ST_OK;
		end else if (adv) begin
			phase_q  <= n_phase;
			uninit_q <= n_uninit;
			cur_op_q <= n_op;
			byte_q   <= n_byte;
			poll_q   <= n_poll;
			retry_q  <= n_retry;
			frame_q  <= n_frame;
			ocr_q    <= n_ocr;
			kind_q   <= n_kind;
			v2_q     <= n_v2;
			fin_st_q <= n_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= r;
		end
	end

	// ---------------- assertions ----------------
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("request stalled with empty input register");

	a_no_xchg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.exchange_request) |->
		(rsp.mosi_byte == 8'd0 && !rsp.chip_select_active))
		else $error("mosi or chip select set without exchange");

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.read_valid && rsp.write_byte_taken))
		else $error("read and write data in one word");

	a_done_no_xchg: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.done_res) |-> !rsp.exchange_request)
		else $error("done word also requests an exchange");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && r.done_res) |=> (phase_q == P_IDLE))
		else $error("sequencer not idle after done");

endmodule

`default_nettype wire

@@ tb/sd_card_spi_host_sequencer_tb.sv @@
// testbench for the sd card spi host sequencer: directed and random request/exchange words
// uses sdspi_pkg types and codes, a built-in sequencer model and a simple card responder

module sd_card_spi_host_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdspi_pkg::*;

	// sequencer phases as the model tracks them
	typedef enum logic [4:0] {
		PH_IDLE, PH_WAKE, PH_RDY, PH_FRAME, PH_R1, PH_OCR, PH_TOKEN, PH_RDATA, PH_RCRC,
		PH_WGAP, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY, PH_SYNC, PH_TAIL
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sd_card_spi_host_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// shared run state
	rsp_t rsp_expected[$];
	int   mismatches = 0;
	int   words_sent = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_left = 0;
	int   card_ok_pct = 100;
	int   pause_after = -1;

	// model copy of the config registers
	logic [15:0] cfg_ready_to;
	logic [7:0]  cfg_resp_polls;
	logic [15:0] cfg_init_retries;
	logic [15:0] cfg_token_to;

	// model copy of the sequencer state
	logic        m_uninit;
	phase_t      m_phase;
	logic [3:0]  m_op;
	logic [2:0]  m_kind;
	status_t     m_final;
	logic [15:0] m_bytes;
	logic [15:0] m_polls;
	logic [15:0] m_retries;
	logic [47:0] m_frame;
	logic [31:0] m_ocr;
	logic        m_v2;
	rsp_t        next_word;

	function void seq_reset();
		cfg_ready_to = 16'd65535;
		cfg_resp_polls = 8'd10;
		cfg_init_retries = 16'd25000;
		cfg_token_to = 16'd50000;
		m_uninit = 1'b1;
		m_phase = PH_IDLE;
		m_op = '0;
		m_kind = KIND_NONE;
		m_final = ST_OK;
		m_bytes = '0;
		m_polls = '0;
		m_retries = '0;
		m_frame = '0;
		m_ocr = '0;
		m_v2 = 1'b0;
	endfunction

	// ask for one exchange and move to the next phase
	function void issue(logic [7:0] mosi, logic cs, phase_t nxt);
		next_word.mosi_byte = mosi;
		next_word.exchange_request = 1'b1;
		next_word.chip_select_active = cs;
		m_phase = nxt;
	endfunction

	// closing 0xff with chip select high, done word follows
	function void close_op(status_t st);
		m_final = st;
		issue(IDLE_BYTE, 1'b0, PH_TAIL);
	endfunction

	function void report_done(logic [3:0] op, status_t st, logic ni);
		m_op = op;
		next_word.done_res = 1'b1;
		next_word.status = st;
		next_word.not_initialized = ni;
		next_word.info_value = '0;
		if (st == ST_OK) begin
			if (op == OP_SCOUNT) next_word.info_value = SECTOR_COUNT;
			else if (op == OP_SSIZE) next_word.info_value = 17'(BLOCK_BYTES_DEF);
			else if (op == OP_BSIZE) next_word.info_value = 17'd1;
		end
	endfunction

	function logic [7:0] frame_byte(logic [15:0] i);
		logic [47:0] sh;
		sh = m_frame >> (40 - 8 * (i % 6));
		return sh[7:0];
	endfunction

	function void send_cmd(logic [7:0] c, logic [31:0] arg);
		logic [7:0] crc;
		crc = CRC_OTHER;
		if (c == C_GO_IDLE) crc = CRC_GO_IDLE;
		if (c == C_IF_COND) crc = CRC_IF_COND;
		m_frame = {c, arg, crc};
		m_polls = 16'd1;
		issue(IDLE_BYTE, 1'b1, PH_RDY);
	endfunction

	function void end_init(logic [2:0] kind);
		m_kind = kind;
		m_uninit = (kind == KIND_NONE);
		close_op(ST_OK);
	endfunction

	function void acmd_attempt();
		if (m_retries == 0) begin
			end_init(KIND_NONE);
		end else begin
			m_retries--;
			send_cmd(C_APP, '0);
		end
	endfunction

	// r1 answer, or 0xff when the card never went ready
	function void on_r1(logic [7:0] r);
		case (m_frame[47:40])
			C_GO_IDLE: begin
				if (r == 8'd1) send_cmd(C_IF_COND, ARG_IF_COND);
				else end_init(KIND_NONE);
			end
			C_IF_COND: begin
				if (r == 8'd1) begin
					m_bytes = '0;
					m_ocr = '0;
					issue(IDLE_BYTE, 1'b1, PH_OCR);
				end else begin
					m_v2 = 1'b0;
					send_cmd(C_APP, '0);
				end
			end
			C_APP: begin
				if (r <= 8'd1) send_cmd(C_OP_COND, m_v2 ? ARG_HCS : 32'd0);
				else if (m_v2) acmd_attempt();
				else end_init(KIND_V1);
			end
			C_OP_COND: begin
				if (m_v2) begin
					if (r == 8'd0) send_cmd(C_READ_OCR, '0);
					else acmd_attempt();
				end else begin
					end_init(r <= 8'd1 ? KIND_V2 : KIND_V1);
				end
			end
			C_READ_OCR: begin
				if (r == 8'd0) begin
					m_bytes = '0;
					m_ocr = '0;
					issue(IDLE_BYTE, 1'b1, PH_OCR);
				end else begin
					end_init(KIND_NONE);
				end
			end
			C_READ_ONE: begin
				if (r == 8'd0) begin
					m_polls = 16'd1;
					issue(IDLE_BYTE, 1'b1, PH_TOKEN);
				end else begin
					close_op(ST_ERR);
				end
			end
			C_WRITE_ONE: begin
				if (r == 8'd0) issue(IDLE_BYTE, 1'b1, PH_WGAP);
				else close_op(ST_ERR);
			end
			default: close_op(ST_ERR);
		endcase
	endfunction

	// host request while idle
	function void start_op(req_t it);
		logic [3:0] op;
		op = it.command;
		if (op == OP_SPI) return;
		if (op > OP_SPI) begin
			report_done(OP_INIT, ST_PARAM, m_uninit);
			return;
		end
		m_op = op;
		if (op == OP_INIT || op == OP_STATUS) begin
			if (it.drive_number) report_done(op, ST_PARAM, 1'b1);
			else if (op == OP_STATUS) report_done(op, ST_OK, m_uninit);
			else begin
				m_bytes = '0;
				issue(IDLE_BYTE, 1'b0, PH_WAKE);
			end
			return;
		end
		if (it.drive_number || ((op == OP_READ || op == OP_WRITE) && it.block_count == 0))
			report_done(op, ST_PARAM, m_uninit);
		else if (m_uninit)
			report_done(op, ST_NOTRDY, m_uninit);
		else if (op == OP_READ || op == OP_WRITE) begin
			if (it.block_count != 8'd1) close_op(ST_ERR);
			else send_cmd(op == OP_READ ? C_READ_ONE : C_WRITE_ONE, it.sector);
		end else if (op == OP_SYNC) begin
			m_polls = 16'd1;
			issue(IDLE_BYTE, 1'b1, PH_SYNC);
		end else begin
			close_op(ST_OK);
		end
	endfunction

	// one exchanged byte while an operation runs
	function void advance(logic [7:0] miso, logic [7:0] wbyte);
		case (m_phase)
			PH_WAKE: begin
				m_bytes++;
				if (m_bytes < 10) issue(IDLE_BYTE, 1'b0, PH_WAKE);
				else send_cmd(C_GO_IDLE, '0);
			end
			PH_RDY: begin
				if (miso == IDLE_BYTE) begin
					m_bytes = '0;
					issue(frame_byte(16'd0), 1'b1, PH_FRAME);
				end else if (m_polls >= cfg_ready_to) on_r1(IDLE_BYTE);
				else begin
					m_polls++;
					issue(IDLE_BYTE, 1'b1, PH_RDY);
				end
			end
			PH_FRAME: begin
				m_bytes++;
				if (m_bytes < 6) issue(frame_byte(m_bytes), 1'b1, PH_FRAME);
				else begin
					m_polls = 16'd1;
					issue(IDLE_BYTE, 1'b1, PH_R1);
				end
			end
			PH_R1: begin
				if (!miso[7] || m_polls >= 16'(cfg_resp_polls)) on_r1(miso);
				else begin
					m_polls++;
					issue(IDLE_BYTE, 1'b1, PH_R1);
				end
			end
			PH_OCR: begin
				m_ocr = {m_ocr[23:0], miso};
				m_bytes++;
				if (m_bytes < 4) issue(IDLE_BYTE, 1'b1, PH_OCR);
				else if (m_frame[47:40] == C_IF_COND) begin
					if (m_ocr[15:0] == ARG_IF_COND[15:0]) begin
						m_v2 = 1'b1;
						m_retries = cfg_init_retries;
						acmd_attempt();
					end else begin
						end_init(KIND_NONE);
					end
				end else begin
					end_init(m_ocr[30] ? KIND_HC : KIND_V2);
				end
			end
			PH_TOKEN: begin
				if (miso == DATA_TOKEN) begin
					m_bytes = '0;
					issue(IDLE_BYTE, 1'b1, PH_RDATA);
				end else if (m_polls >= cfg_token_to) close_op(ST_ERR);
				else begin
					m_polls++;
					issue(IDLE_BYTE, 1'b1, PH_TOKEN);
				end
			end
			PH_RDATA: begin
				next_word.read_byte = miso;
				next_word.read_valid = 1'b1;
				if (int'(m_bytes) + 1 < BLOCK_BYTES_DEF) begin
					m_bytes++;
					issue(IDLE_BYTE, 1'b1, PH_RDATA);
				end else begin
					m_bytes = '0;
					issue(IDLE_BYTE, 1'b1, PH_RCRC);
				end
			end
			PH_RCRC: begin
				if (m_bytes == 0) begin
					m_bytes = 16'd1;
					issue(IDLE_BYTE, 1'b1, PH_RCRC);
				end else close_op(ST_OK);
			end
			PH_WGAP: issue(DATA_TOKEN, 1'b1, PH_WTOKEN);
			PH_WTOKEN: begin
				m_bytes = '0;
				next_word.write_byte_taken = 1'b1;
				issue(wbyte, 1'b1, PH_WDATA);
			end
			PH_WDATA: begin
				if (int'(m_bytes) + 1 < BLOCK_BYTES_DEF) begin
					m_bytes++;
					next_word.write_byte_taken = 1'b1;
					issue(wbyte, 1'b1, PH_WDATA);
				end else begin
					m_bytes = '0;
					issue(IDLE_BYTE, 1'b1, PH_WCRC);
				end
			end
			PH_WCRC: begin
				if (m_bytes == 0) begin
					m_bytes = 16'd1;
					issue(IDLE_BYTE, 1'b1, PH_WCRC);
				end else issue(IDLE_BYTE, 1'b1, PH_WRESP);
			end
			PH_WRESP: begin
				if (miso[4:0] == DRESP_OK) issue(IDLE_BYTE, 1'b1, PH_WBUSY);
				else close_op(ST_ERR);
			end
			PH_WBUSY: begin
				if (miso == 8'd0) issue(IDLE_BYTE, 1'b1, PH_WBUSY);
				else close_op(ST_OK);
			end
			PH_SYNC: begin
				if (miso == IDLE_BYTE) close_op(ST_OK);
				else if (m_polls >= cfg_ready_to) close_op(ST_ERR);
				else begin
					m_polls++;
					issue(IDLE_BYTE, 1'b1, PH_SYNC);
				end
			end
			PH_TAIL: begin
				m_phase = PH_IDLE;
				report_done(m_op, m_final, m_uninit);
			end
			default: m_phase = PH_IDLE;
		endcase
	endfunction

	// every accepted word yields exactly one response word
	function void seq_step(req_t it);
		next_word = '0;
		next_word.not_initialized = m_uninit;
		if (m_phase == PH_IDLE) start_op(it);
		else advance(it.miso_byte, it.write_byte);
		rsp_expected.push_back(next_word);
	endfunction

	// card side: pick the byte the card returns for the pending exchange
	function logic [7:0] card_byte();
		logic       ok;
		logic [7:0] rnd;
		ok = $urandom_range(0, 99) < card_ok_pct;
		rnd = 8'($urandom_range(0, 255));
		if (!ok) return rnd;
		case (m_phase)
			PH_RDY, PH_SYNC: return IDLE_BYTE;
			PH_R1: begin
				case (m_frame[47:40])
					C_GO_IDLE, C_IF_COND, C_APP: return 8'd1;
					C_OP_COND: return m_v2 ? 8'd0 : 8'($urandom_range(0, 1));
					default: return 8'd0;
				endcase
			end
			PH_OCR: begin
				if (m_frame[47:40] == C_IF_COND)
					return (m_bytes == 3) ? 8'hAA : (m_bytes == 2) ? 8'h01 : 8'h00;
				return (m_bytes == 0) ? {rnd[7], ~rnd[0] | (card_ok_pct == 100), rnd[5:0]} : rnd;
			end
			PH_TOKEN: return DATA_TOKEN;
			PH_WRESP: return {rnd[7:5], DRESP_OK};
			PH_WBUSY: return $urandom_range(0, 1) ? 8'd0 : rnd;
			default: return rnd;
		endcase
	endfunction

	// send one word, idling at random first
	task automatic send_word(req_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		words_sent++;
		seq_step(it);
	endtask

	// wait until every predicted word has come back
	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_expected.size() != 0) @(posedge clk);
	endtask

	// one host request, then exchange words until the model is idle again
	task automatic run_op(logic [3:0] op, logic drv, logic [31:0] sector, logic [7:0] cnt);
		req_t it;
		int   n;
		it.command = op;
		it.drive_number = drv;
		it.sector = sector;
		it.block_count = cnt;
		it.miso_byte = 8'($urandom_range(0, 255));
		it.write_byte = 8'($urandom_range(0, 255));
		send_word(it);
		n = 0;
		while (m_phase != PH_IDLE) begin
			// the command field is junk here, the block must ignore it
			it.command = 4'($urandom_range(0, 15));
			it.drive_number = 1'($urandom_range(0, 1));
			it.sector = $urandom;
			it.block_count = 8'($urandom_range(0, 255));
			it.miso_byte = card_byte();
			it.write_byte = 8'($urandom_range(0, 255));
			send_word(it);
			n++;
			if (n == pause_after) drain();
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_READY_TO: cfg_ready_to = val[15:0];
			REG_RESP_POLLS: cfg_resp_polls = val[7:0];
			REG_INIT_RETRIES: cfg_init_retries = val[15:0];
			default: cfg_token_to = val[15:0];
		endcase
	endtask

	// config only while nothing is in flight; the wait after the drain covers the pipeline
	task automatic set_config(int rt, int rp, int ir, int tt);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_READY_TO, rt);
		write_reg(REG_RESP_POLLS, rp);
		write_reg(REG_INIT_RETRIES, ir);
		write_reg(REG_TOKEN_TO, tt);
	endtask

	// requests that finish at once: bad commands, bad drive, zero count, not ready, status, spi byte
	task automatic test_immediate();
		run_op(4'd9, 1'b0, 32'd0, 8'd1);
		run_op(4'd15, 1'b1, 32'hFFFF_FFFF, 8'd255);
		run_op(OP_SPI, 1'b0, 32'd0, 8'd0);
		run_op(OP_STATUS, 1'b0, 32'd0, 8'd1);
		run_op(OP_INIT, 1'b1, 32'd0, 8'd1);
		run_op(OP_STATUS, 1'b1, 32'd0, 8'd1);
		run_op(OP_READ, 1'b0, 32'd0, 8'd0);
		run_op(OP_WRITE, 1'b0, 32'd0, 8'd0);
		run_op(OP_READ, 1'b0, 32'd5, 8'd1);
		run_op(OP_WRITE, 1'b0, 32'd5, 8'd1);
		run_op(OP_SYNC, 1'b0, 32'd0, 8'd1);
		run_op(OP_SCOUNT, 1'b0, 32'd0, 8'd1);
		run_op(OP_SSIZE, 1'b1, 32'd0, 8'd1);
		run_op(OP_BSIZE, 1'b0, 32'd0, 8'd1);
	endtask

	// full init with a well-behaved high capacity card, then the queries
	task automatic test_init_and_queries();
		run_op(OP_INIT, 1'b0, 32'd0, 8'd1);
		run_op(OP_STATUS, 1'b0, 32'd0, 8'd1);
		run_op(OP_SCOUNT, 1'b0, 32'd0, 8'd1);
		run_op(OP_SSIZE, 1'b0, 32'd0, 8'd1);
		run_op(OP_BSIZE, 1'b0, 32'd0, 8'd1);
		run_op(OP_SYNC, 1'b0, 32'd0, 8'd1);
	endtask

	// single block read and write at the sector extremes, count above one
	task automatic test_transfers();
		run_op(OP_READ, 1'b0, 32'd0, 8'd2);
		run_op(OP_WRITE, 1'b0, 32'hFFFF_FFFF, 8'd255);
		run_op(OP_READ, 1'b0, 32'hFFFF_FFFF, 8'd1);
		run_op(OP_WRITE, 1'b0, 32'd0, 8'd1);
	endtask

	// receiver stalls long while requests keep coming, then a mid-op drain
	task automatic test_pressure();
		hold_left = 300;
		repeat (40) run_op(4'($urandom_range(OP_STATUS, OP_SPI)), 1'b0, $urandom, 8'd1);
		pause_after = 5;
		run_op(OP_INIT, 1'b0, 32'd0, 8'd1);
		pause_after = -1;
	endtask

	task automatic test_random(int n_words);
		int          start;
		int          pick;
		logic [3:0]  op;
		logic        drv;
		logic [7:0]  cnt;
		start = words_sent;
		while (words_sent - start < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) op = OP_INIT;
			else if (pick < 26) op = OP_STATUS;
			else if (pick < 30) op = OP_READ;
			else if (pick < 34) op = OP_WRITE;
			else if (pick < 55) op = OP_SYNC;
			else if (pick < 85) op = 4'($urandom_range(OP_SCOUNT, OP_SPI));
			else op = 4'($urandom_range(0, 15));
			drv = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 9);
			cnt = (pick < 7) ? 8'd1 : (pick < 8) ? 8'd0 : 8'($urandom_range(2, 255));
			run_op(op, drv, $urandom, cnt);
		end
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response word %p", rsp);
			end else begin
				want = rsp_expected.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch\n  expected %p\n  actual   %p", want, rsp);
				end
			end
		end
	end

	// receiver: long hold-off when asked, else random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		seq_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 32;
		recv_idle_pct = 82;
		test_immediate();
		test_init_and_queries();
		test_transfers();
		test_pressure();

		// low extremes, sender idle 32 / receiver 82
		set_config(1, 1, 1, 1);
		card_ok_pct = 75;
		test_random(150);

		// high extremes, idling swapped
		set_config(65535, 255, 65535, 65535);
		send_idle_pct = 82;
		recv_idle_pct = 32;
		test_random(150);

		// middle values, no idling
		set_config(4, 3, 3, 5);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(150);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/sdspi_pkg.sv
hw/rtl/sd_card_spi_host_sequencer.sv
tb/sd_card_spi_host_sequencer_tb.sv
